[hw/rtl/base64_codec_with_wrap_macros.svh]
// ----------------------------------------------------------------------------
// base64 codec assertion macros
// Shorthand for the concurrent checks in the codec top level.
// ----------------------------------------------------------------------------
`ifndef BASE64_CODEC_WITH_WRAP_MACROS_SVH
`define BASE64_CODEC_WITH_WRAP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define B64CW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define B64CW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/b64cw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64cw_pkg
// Shared types, constants and alphabet functions for the base64 codec.
// ----------------------------------------------------------------------------
package b64cw_pkg;

    localparam int RES_MAX   = 6;
    localparam int RES_IDX_W = $clog2(RES_MAX);
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_INVALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH   = 2'd2;

    localparam logic [15:0] WRAP_RESET = 16'd76;
    localparam logic [7:0]  CH_PAD     = 8'h3D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_CR      = 8'h0D;

    // results of one item, delivered in order data[0] .. data[cnt-1]
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] data;
        logic [RES_CNT_W-1:0]    cnt;
        logic                    err;   // lone error result
    } res_list_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  carry;
        logic [15:0] column;
    } enc_state_t;

    typedef struct packed {
        logic [11:0] acc;
        logic [3:0]  bits;
    } dec_state_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)       return w + 8'h41;
        else if (v < 6'd52)  return w + 8'd71;
        else if (v < 6'd62)  return w - 8'd4;
        else if (v == 6'd62) return 8'h2B;
        else                 return 8'h2F;
    endfunction

    // alphabet character to 6-bit value; ok low outside the alphabet
    function automatic sextet_t char_sextet(input logic [7:0] c);
        sextet_t s;
        s = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.ok = 1'b1; s.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.ok = 1'b1; s.val = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.ok = 1'b1; s.val = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            s.ok = 1'b1; s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.ok = 1'b1; s.val = 6'd63;
        end
        return s;
    endfunction

endpackage

[hw/rtl/b64cw_enc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64cw_enc
// Encode step: one byte or end marker to characters, padding and newlines.
// ----------------------------------------------------------------------------
module b64cw_enc (
    input  logic [7:0]            in_byte,
    input  logic                  in_end,
    input  b64cw_pkg::enc_state_t st,
    input  logic [15:0]           wrap_width,
    output b64cw_pkg::res_list_t  res,
    output b64cw_pkg::enc_state_t nxt
);
    import b64cw_pkg::*;

    logic [2:0][7:0]      chars;
    logic [1:0]           nch;
    logic [15:0]          col;
    logic [RES_CNT_W-1:0] n;

    // characters of this item
    always_comb
    begin
        chars = '0;
        nch   = 2'd0;
        nxt   = st;
        if (in_end)
        begin
            nxt = '0;
            case (st.phase)
                2'd1:
                begin
                    chars[0] = sextet_char({st.carry[1:0], 4'b0000});
                    chars[1] = CH_PAD;
                    chars[2] = CH_PAD;
                    nch      = 2'd3;
                end
                2'd2:
                begin
                    chars[0] = sextet_char({st.carry[3:0], 2'b00});
                    chars[1] = CH_PAD;
                    nch      = 2'd2;
                end
                default: ;
            endcase
        end
        else
        begin
            case (st.phase)
                2'd1:
                begin
                    chars[0]  = sextet_char({st.carry[1:0], in_byte[7:4]});
                    nch       = 2'd1;
                    nxt.carry = {4'b0000, in_byte[3:0]};
                    nxt.phase = 2'd2;
                end
                2'd2:
                begin
                    chars[0]  = sextet_char({st.carry[3:0], in_byte[7:6]});
                    chars[1]  = sextet_char(in_byte[5:0]);
                    nch       = 2'd2;
                    nxt.carry = 8'h00;
                    nxt.phase = 2'd0;
                end
                default:
                begin
                    chars[0]  = sextet_char(in_byte[7:2]);
                    nch       = 2'd1;
                    nxt.carry = {6'b000000, in_byte[1:0]};
                    nxt.phase = 2'd1;
                end
            endcase
        end

        // place characters, a newline after each one that fills the line and one to close an open line at the end
        res = '0;
        n   = '0;
        col = st.column;
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < nch)
            begin
                res.data[RES_IDX_W'(n)] = chars[k];
                n = n + 1'b1;
                if (wrap_width != 16'd0)
                begin
                    col = col + 16'd1;
                    if (col == wrap_width)
                    begin
                        res.data[RES_IDX_W'(n)] = CH_LF;
                        n   = n + 1'b1;
                        col = 16'd0;
                    end
                end
            end
        end
        if (in_end && wrap_width != 16'd0 && col != 16'd0)
        begin
            res.data[RES_IDX_W'(n)] = CH_LF;
            n = n + 1'b1;
        end
        res.cnt    = n;
        nxt.column = in_end ? 16'd0 : col;
    end

endmodule

[hw/rtl/b64cw_dec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64cw_dec
// Decode step: one text character to at most one byte or an error result.
// ----------------------------------------------------------------------------
module b64cw_dec (
    input  logic [7:0]            in_byte,
    input  b64cw_pkg::dec_state_t st,
    input  logic                  skip_invalid,
    output b64cw_pkg::res_list_t  res,
    output b64cw_pkg::dec_state_t nxt,
    output logic                  halt_set
);
    import b64cw_pkg::*;

    sextet_t    sx;
    logic       is_ws;
    logic [3:0] bits6;
    logic [3:0] rem;

    assign sx    = char_sextet(in_byte);
    assign is_ws = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
    assign bits6 = st.bits + 4'd6;
    assign rem   = bits6 - 4'd8;

    always_comb
    begin
        res      = '0;
        nxt      = st;
        halt_set = 1'b0;
        if (in_byte == CH_PAD)
        begin
            halt_set = 1'b1;
        end
        else if (!sx.ok)
        begin
            if (!is_ws && !skip_invalid)
            begin
                res.cnt  = RES_CNT_W'(1);
                res.err  = 1'b1;
                halt_set = 1'b1;
            end
        end
        else
        begin
            nxt.acc = {st.acc[5:0], sx.val};
            if (bits6 >= 4'd8)
            begin
                nxt.bits    = rem;
                res.data[0] = 8'(nxt.acc >> rem);
                res.cnt     = RES_CNT_W'(1);
            end
            else
            begin
                nxt.bits = bits6;
            end
        end
    end

endmodule

[hw/rtl/b64cw_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64cw_emit
// Result buffer: holds one item's results and sends them one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module b64cw_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  b64cw_pkg::res_list_t load_list,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import b64cw_pkg::*;

    res_list_t            list_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 busy;
    logic                 last;

    assign busy     = idx_reg < list_reg.cnt;
    assign last     = idx_reg == (list_reg.cnt - 1'b1);
    assign can_load = !busy || (m_tready && last);

    assign m_tvalid = busy;
    assign m_tdata  = busy ? list_reg.data[RES_IDX_W'(idx_reg)] : 8'h00;
    assign m_tuser  = list_reg.err;
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_reg <= '0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            list_reg <= load_list;
            idx_reg  <= '0;
        end
        else if (busy && m_tready)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

[hw/rtl/base64_codec_with_wrap.sv]
`timescale 1ns / 1ps
`include "base64_codec_with_wrap_macros.svh"
// ----------------------------------------------------------------------------
// base64_codec_with_wrap
// Streaming base64 encoder/decoder with line wrapping, one byte per transaction.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata / data          | tuser          | tlast
//  s_axis    | in  | [7:0] in_byte         | end_of_input   | -
//  m_axis    | out | [7:0] out_byte        | invalid_input  | last_of_run
//  cfg       | in  | cfg_index, cfg_data   | -              | -
//
//  An input transaction lands in an input register; its results (0 to 6) are
//  computed there and loaded into the single-output result buffer when it is
//  empty or its last result is being taken. The buffer sends one result per
//  cycle while m_tready is high.
//  Reset clears codec state, decode_mode, skip_invalid; wrap_width -> 76.
//  m_tready low holds the current result; s_tready drops once the input
//  register holds an item that the result buffer cannot take.
// ----------------------------------------------------------------------------
module base64_codec_with_wrap (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] in_byte
    input  logic                               s_tuser,   // [0] end_of_input
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tuser,   // [0] invalid_input
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [b64cw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [b64cw_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import b64cw_pkg::*;

    // configuration registers
    logic        decode_mode_reg;
    logic        skip_invalid_reg;
    logic [15:0] wrap_width_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    // codec state (encode and decode keep separate state)
    enc_state_t  enc_reg;
    dec_state_t  dec_reg;
    logic        halted_reg;

    enc_state_t  enc_next;
    dec_state_t  dec_next;
    logic        dec_halt;
    res_list_t   enc_res;
    res_list_t   dec_res;
    res_list_t   sel_res;
    logic        can_load;
    logic        move;

    // item leaves the input register when the result buffer can take it
    assign move     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg  <= 1'b0;
            skip_invalid_reg <= 1'b0;
            wrap_width_reg   <= WRAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DECODE_MODE:  decode_mode_reg  <= cfg_data[0];
                REG_SKIP_INVALID: skip_invalid_reg <= cfg_data[0];
                REG_WRAP_WIDTH:   wrap_width_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    b64cw_enc u_enc (
        .in_byte    (in_byte_reg),
        .in_end     (in_end_reg),
        .st         (enc_reg),
        .wrap_width (wrap_width_reg),
        .res        (enc_res),
        .nxt        (enc_next)
    );

    b64cw_dec u_dec (
        .in_byte      (in_byte_reg),
        .st           (dec_reg),
        .skip_invalid (skip_invalid_reg),
        .res          (dec_res),
        .nxt          (dec_next),
        .halt_set     (dec_halt)
    );

    // end item: encode flush unless halted; decode end gives nothing
    always_comb
    begin
        if (in_end_reg)
            sel_res = (!halted_reg && !decode_mode_reg) ? enc_res : '0;
        else if (halted_reg)
            sel_res = '0;
        else
            sel_res = decode_mode_reg ? dec_res : enc_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg    <= '0;
            dec_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (move)
        begin
            if (in_end_reg)
            begin
                enc_reg    <= '0;
                dec_reg    <= '0;
                halted_reg <= 1'b0;
            end
            else if (!halted_reg)
            begin
                if (decode_mode_reg)
                begin
                    dec_reg    <= dec_next;
                    halted_reg <= dec_halt;
                end
                else
                begin
                    enc_reg <= enc_next;
                end
            end
        end
    end

    b64cw_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .load_list (sel_res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // error result stands alone and carries a zero byte
    `B64CW_ASSERT_NOW(a_err_alone, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00), "error result not alone")
    // end item clears all codec state
    `B64CW_ASSERT_NEXT(a_end_clears, move && in_end_reg, (enc_reg == '0) && (dec_reg == '0) && !halted_reg, "end item left state")
    // halted non-end items produce no output
    `B64CW_ASSERT_NEXT(a_halt_quiet, move && halted_reg && !in_end_reg, !m_tvalid, "output while halted")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64 codec testbench
// Drives byte streams through the codec in encode and decode mode, predicts
// every output byte, error flag and end-of-run marker from its own copy of
// the codec state, and checks each result transaction in order. Random
// gaps on the input side and backpressure on the output side are mixed in.
// ----------------------------------------------------------------------------
module testbench;

    import b64cw_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int QUIET_LIMIT    = 5000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 6;     // covers the input register and result-less items
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one result transaction
    typedef struct {
        logic [7:0] ch;
        logic       err;
        logic       last;
    } b64_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and DUT signals
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;   // [7:0] in_byte
    logic                  s_tuser   = 1'b0;    // [0] end_of_input
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [7:0]            m_tdata;             // [7:0] out_byte
    logic                  m_tuser;             // [0] invalid_input
    logic                  m_tlast;             // last_of_run
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    always #CLK_HALF clk = ~clk;

    base64_codec_with_wrap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------------
    b64_result_t pending_results[$];   // predicted, not yet seen on m_axis
    b64_result_t run_buf[0:7];          // results of the item being predicted
    int          run_len;
    int          err_count     = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    logic        idle_on       = 1'b1;  // random gaps / backpressure enabled

    // predictor copy of the registers
    logic        cfg_decode;
    logic        cfg_ignore;
    logic [15:0] cfg_wrap;

    // predictor copy of the codec state
    logic [1:0]  enc_phase;
    logic [7:0]  enc_carry;
    logic [15:0] enc_column;
    logic [11:0] dec_acc;
    logic [3:0]  dec_bits;
    logic        halted;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        int n;
        n = int'(v);
        if (n < 26)       return 8'("A" + n);
        else if (n < 52)  return 8'("a" + n - 26);
        else if (n < 62)  return 8'("0" + n - 52);
        else if (n == 62) return "+";
        else              return "/";
    endfunction

    // -1 outside the alphabet
    function automatic int char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "a" && c <= "z") return int'(c - "a") + 26;
        if (c >= "0" && c <= "9") return int'(c - "0") + 52;
        if (c == "+")             return 62;
        if (c == "/")             return 63;
        return -1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic clear_codec();
        enc_phase  = '0;
        enc_carry  = '0;
        enc_column = '0;
        dec_acc    = '0;
        dec_bits   = '0;
        halted     = 1'b0;
    endtask

    task automatic add_result(input logic [7:0] ch, input logic err);
        run_buf[run_len].ch   = ch;
        run_buf[run_len].err  = err;
        run_buf[run_len].last = 1'b0;
        run_len++;
    endtask

    // encoded character, followed by a line feed when the column hits the wrap
    task automatic add_text_char(input logic [7:0] ch);
        add_result(ch, 1'b0);
        if (cfg_wrap != 0) begin
            enc_column = enc_column + 16'd1;
            if (enc_column == cfg_wrap) begin
                add_result(CH_LF, 1'b0);
                enc_column = '0;
            end
        end
    endtask

    task automatic predict_item(input logic [7:0] b, input logic e);
        int v;
        run_len = 0;
        if (e) begin
            if (!halted && !cfg_decode) begin
                if (enc_phase == 2'd1) begin
                    add_text_char(sextet_to_char({enc_carry[1:0], 4'b0000}));
                    add_text_char(CH_PAD);
                    add_text_char(CH_PAD);
                end else if (enc_phase == 2'd2) begin
                    add_text_char(sextet_to_char({enc_carry[3:0], 2'b00}));
                    add_text_char(CH_PAD);
                end
                if (cfg_wrap != 0 && enc_column != 0)
                    add_result(CH_LF, 1'b0);
            end
            clear_codec();
        end else if (halted) begin
            // swallowed until the end item
        end else if (!cfg_decode) begin
            if (enc_phase == 2'd1) begin
                add_text_char(sextet_to_char({enc_carry[1:0], b[7:4]}));
                enc_carry = {4'b0000, b[3:0]};
                enc_phase = 2'd2;
            end else if (enc_phase == 2'd2) begin
                add_text_char(sextet_to_char({enc_carry[3:0], b[7:6]}));
                add_text_char(sextet_to_char(b[5:0]));
                enc_carry = '0;
                enc_phase = 2'd0;
            end else begin
                // phase 0, and the unused phase 3 behaves the same
                add_text_char(sextet_to_char(b[7:2]));
                enc_carry = {6'b000000, b[1:0]};
                enc_phase = 2'd1;
            end
        end else if (b == CH_PAD) begin
            halted = 1'b1;
        end else begin
            v = char_value(b);
            if (v < 0) begin
                if (!is_blank(b) && !cfg_ignore) begin
                    add_result(8'h00, 1'b1);
                    halted = 1'b1;
                end
            end else begin
                dec_acc  = {dec_acc[5:0], 6'(v)};
                dec_bits = dec_bits + 4'd6;
                if (dec_bits >= 4'd8) begin
                    dec_bits = dec_bits - 4'd8;
                    add_result(8'(dec_acc >> dec_bits), 1'b0);
                end
            end
        end
        if (run_len > 0)
            run_buf[run_len-1].last = 1'b1;
        for (int i = 0; i < run_len; i++)
            pending_results.push_back(run_buf[i]);
    endtask

    // ------------------------------------------------------------------------
    // output side: random backpressure bursts of stalled cycles
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk) begin
        if (!rst_n || !idle_on) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result checker: every m_axis transaction against the oldest prediction
    // ------------------------------------------------------------------------
    b64_result_t want;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing predicted: expected none, actual byte %h err %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_tdata !== want.ch) begin
                    err_count++;
                    $display("%0t: out_byte mismatch: expected %h actual %h",
                             $time, want.ch, m_tdata);
                end
                if (m_tuser !== want.err) begin
                    err_count++;
                    $display("%0t: invalid_input mismatch: expected %b actual %b",
                             $time, want.err, m_tuser);
                end
                if (m_tlast !== want.last) begin
                    err_count++;
                    $display("%0t: last_of_run mismatch: expected %b actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on either stream
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired, %0d results still outstanding",
                         $time, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // input side idles, then waits until every predicted result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // one input transaction; prediction once it has been accepted
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= e;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(b, e);
        items_sent++;
        // sender holds off now and then until the output has caught up
        if (idle_on && $urandom_range(0, 39) == 0)
            drain_results();
    endtask

    // register write, only with the codec drained and settled
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DECODE_MODE)
            cfg_decode = val[0];
        else if (idx == REG_SKIP_INVALID)
            cfg_ignore = val[0];
        else if (idx == REG_WRAP_WIDTH)
            cfg_wrap = val;
        @(posedge clk);
    endtask

    // 1-bit registers written with random upper bits that must be dropped
    function automatic logic [CFG_DAT_W-1:0] flag_word(input logic bit_value);
        return (CFG_DAT_W'($urandom) & ~CFG_DAT_W'(1)) | CFG_DAT_W'(bit_value);
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // encode with the reset settings: byte extremes and flush of every phase
    task automatic test_encode_directed();
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);                  // one byte held: two pads
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);                  // two bytes held: one pad
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hA5, 1'b1);                  // full group: only the line end
        send_item(8'h3C, 1'b1);                  // nothing pending: no result
    endtask

    // decode: alphabet edges, whitespace, pad stop, error and halt
    task automatic test_decode_directed();
        set_reg(REG_DECODE_MODE, flag_word(1'b1));
        send_item("T", 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item("W", 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item("/", 1'b0);
        send_item("+", 1'b0);
        send_item(CH_LF, 1'b0);
        send_item("z", 1'b0);
        send_item("9", 1'b0);
        send_item(CH_PAD, 1'b0);                 // stops decoding
        send_item("A", 1'b0);                    // ignored while stopped
        send_item(8'hFF, 1'b1);
        send_item("!", 1'b0);                    // invalid: error result
        send_item("Q", 1'b0);                    // ignored after the error
        send_item(8'h00, 1'b1);
    endtask

    // random byte runs at a spread of wrap widths, extremes included
    task automatic test_encode_random();
        logic [15:0] wrap_list [0:7];
        int          k;
        int          len;
        wrap_list[0] = 16'd0;
        wrap_list[1] = 16'd1;
        wrap_list[2] = 16'd2;
        wrap_list[3] = 16'd3;
        wrap_list[4] = 16'd4;
        wrap_list[5] = WRAP_RESET;
        wrap_list[6] = 16'hFFFF;
        wrap_list[7] = 16'($urandom_range(5, 100));
        set_reg(REG_DECODE_MODE, flag_word(1'b0));
        set_reg(REG_UNUSED, CFG_DAT_W'($urandom));   // no register there
        for (int w = 0; w < 8; w++) begin
            set_reg(REG_WRAP_WIDTH, wrap_list[w]);
            k = 0;
            while (k < 32) begin
                len = $urandom_range(0, 12);
                repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
                k += len + 1;
            end
        end
    endtask

    // mostly well-formed padded text with whitespace, some raw noise
    task automatic test_decode_random();
        int k;
        int groups;
        int pads;
        set_reg(REG_DECODE_MODE, flag_word(1'b1));
        for (int c = 0; c < 4; c++) begin
            set_reg(REG_SKIP_INVALID, flag_word(c[0]));
            k = 0;
            while (k < 38) begin
                if ($urandom_range(0, 3) != 0) begin
                    groups = $urandom_range(1, 4);
                    pads   = $urandom_range(0, 2);
                    for (int i = 0; i < 4 * groups - pads; i++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_item(random_blank(), 1'b0);
                            k++;
                        end
                        send_item(sextet_to_char(6'($urandom_range(0, 63))), 1'b0);
                        k++;
                    end
                    repeat (pads) send_item(CH_PAD, 1'b0);
                    k += pads;
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                        k++;
                    end
                end
                // the odd run carries its state into the next one
                if ($urandom_range(0, 7) != 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b1);
                    k++;
                end
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // encode and decode keep separate state; the halt flag is shared
    task automatic test_mode_switch();
        set_reg(REG_SKIP_INVALID, flag_word(1'b0));
        set_reg(REG_DECODE_MODE, flag_word(1'b0));
        set_reg(REG_WRAP_WIDTH, WRAP_RESET);
        send_item(8'hC3, 1'b0);                  // encoder holds one byte
        set_reg(REG_DECODE_MODE, flag_word(1'b1));
        send_item("Q", 1'b0);
        send_item("U", 1'b0);                    // decoder emits a byte
        send_item("J", 1'b0);                    // another byte, 2 bits held
        set_reg(REG_DECODE_MODE, flag_word(1'b0));
        send_item(8'h7E, 1'b0);                  // encoder resumes its group
        set_reg(REG_DECODE_MODE, flag_word(1'b1));
        send_item("B", 1'b0);                    // uses the held decode bits
        send_item("#", 1'b0);                    // error, halts both modes
        set_reg(REG_DECODE_MODE, flag_word(1'b0));
        send_item(8'h11, 1'b0);                  // swallowed while halted
        send_item(8'h22, 1'b1);                  // halted end: no flush
        send_item(8'h33, 1'b0);
        send_item(8'h44, 1'b1);
    endtask

    // wrap shrunk below the column: the count runs on with no line break
    task automatic test_column_wraparound();
        idle_on <= 1'b0;
        set_reg(REG_DECODE_MODE, flag_word(1'b0));
        set_reg(REG_WRAP_WIDTH, 16'd100);
        repeat (30) send_item(8'($urandom_range(0, 255)), 1'b0);   // column 40
        set_reg(REG_WRAP_WIDTH, 16'd20);
        repeat (20) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_decode = 1'b0;
        cfg_ignore = 1'b0;
        cfg_wrap   = WRAP_RESET;
        clear_codec();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_encode_random();
        test_decode_random();
        test_mode_switch();
        test_column_wraparound();

        drain_results();
        repeat (20) @(posedge clk);

        $display("Encode at wraps 0..65535, decode with and without garbage skipping,");
        $display("mode switches and a wrap shrunk below the column: %0d items, %0d results, %0d errors",
                 items_sent, results_seen, err_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/b64cw_pkg.sv
hw/rtl/b64cw_enc.sv
hw/rtl/b64cw_dec.sv
hw/rtl/b64cw_emit.sv
hw/rtl/base64_codec_with_wrap.sv
test/testbench.sv
